FILE: hw/rtl/lqr_pkg.sv
package lqr_pkg;

    // Queue geometry.
    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed port field widths.
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 4;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] push_value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pop_value;
        logic [STATUS_W-1:0]       status;
        logic [HELD_W-1:0]         held_count;
    } res_item_t;

endpackage

FILE: hw/rtl/linear_queue_with_reverse.sv
// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid / cmd_stall  lqr_pkg::cmd_item_t (cmd, push_value)
// res       out        res_valid / res_stall  lqr_pkg::res_item_t (pop_value, status, held_count)
//
// Enqueue, the unused code and dequeue or reverse of an empty queue finish in the idle state,
// so they may follow one another in every cycle while the result side does not stall. Dequeue
// of a held word passes through the POP state for the registered read of the slot memory.
// Reverse of a held queue copies one slot a cycle in the REV state, then swaps banks in REV_END.
// Reset clears the indices and marks the queue empty; slot memory is not cleared.
// A command is taken only in the idle state while the result register is free or being drained.
module linear_queue_with_reverse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  lqr_pkg::cmd_item_t  cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output lqr_pkg::res_item_t  res_data
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_POP     = 2'd1;
    localparam logic [1:0] ST_REV     = 2'd2;
    localparam logic [1:0] ST_REV_END = 2'd3;

    localparam lqr_pkg::idx_t LAST_IDX = lqr_pkg::IDX_W'(lqr_pkg::DEPTH - 1);

    logic [1:0]         state_reg, state_next;
    lqr_pkg::idx_t      head_reg, head_next;
    lqr_pkg::idx_t      tail_reg, tail_next;
    logic               empty_reg, empty_next;
    logic               sel_reg, sel_next;
    lqr_pkg::idx_t      cnt_reg, cnt_next;
    logic               wr_pend_reg, wr_pend_next;
    lqr_pkg::idx_t      wr_addr_reg, wr_addr_next;
    logic               res_valid_reg, res_valid_next;
    lqr_pkg::res_item_t res_reg, res_next;

    logic               accept;
    logic               load_res;
    logic [63:0]        push_wide;
    lqr_pkg::word_t     push_word;
    logic [63:0]        pop_wide;

    logic               act_we, oth_we;
    lqr_pkg::idx_t      act_waddr, oth_waddr, act_raddr;
    lqr_pkg::word_t     act_wdata, oth_wdata, act_rdata;
    logic               we0, we1;
    lqr_pkg::idx_t      waddr0, waddr1;
    lqr_pkg::word_t     wdata0, wdata1, rdata0, rdata1;

    // Number of words held for a given set of indices.
    function automatic logic [lqr_pkg::HELD_W-1:0] held_of(
        input logic          e,
        input lqr_pkg::idx_t h,
        input lqr_pkg::idx_t t
    );
        logic [63:0] n;
        n = e ? 64'd0 : (64'(t - h) + 64'd1);
        return n[lqr_pkg::HELD_W-1:0];
    endfunction

    // Word width conversions between port fields and memory words.
    assign push_wide = 64'($unsigned(cmd_data.push_value));
    assign push_word = push_wide[lqr_pkg::DATA_WIDTH-1:0];
    assign pop_wide  = 64'(act_rdata);

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = !((state_reg == ST_IDLE) && (!res_valid_reg || !res_stall));
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Two banks: the live one holds the queue, the spare one receives a reversal.
    assign we0       = sel_reg ? oth_we    : act_we;
    assign waddr0    = sel_reg ? oth_waddr : act_waddr;
    assign wdata0    = sel_reg ? oth_wdata : act_wdata;
    assign we1       = sel_reg ? act_we    : oth_we;
    assign waddr1    = sel_reg ? act_waddr : oth_waddr;
    assign wdata1    = sel_reg ? act_wdata : oth_wdata;
    assign act_rdata = sel_reg ? rdata1    : rdata0;

    lqr_ram #(
        .WIDTH (lqr_pkg::DATA_WIDTH),
        .DEPTH (lqr_pkg::DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .raddr (act_raddr),
        .rdata (rdata0)
    );

    lqr_ram #(
        .WIDTH (lqr_pkg::DATA_WIDTH),
        .DEPTH (lqr_pkg::DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .raddr (act_raddr),
        .rdata (rdata1)
    );

    // Command sequencer. A write always lands before the next command can read,
    // so no forwarding is needed.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        load_res       = 1'b0;
        act_we         = 1'b0;
        act_waddr      = '0;
        act_wdata      = push_word;
        act_raddr      = head_reg;
        oth_we         = 1'b0;
        oth_waddr      = wr_addr_reg;
        oth_wdata      = act_rdata;

        res_next.pop_value = '0;
        res_next.status    = lqr_pkg::STATUS_OK;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_data.cmd)
                        lqr_pkg::CMD_ENQUEUE:
                        begin
                            load_res = 1'b1;
                            if (empty_reg)
                            begin
                                act_we     = 1'b1;
                                act_waddr  = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                            end
                            else if (tail_reg == LAST_IDX)
                            begin
                                res_next.status = lqr_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                act_we    = 1'b1;
                                act_waddr = tail_reg + lqr_pkg::IDX_W'(1);
                                tail_next = tail_reg + lqr_pkg::IDX_W'(1);
                            end
                        end
                        lqr_pkg::CMD_DEQUEUE:
                        begin
                            if (empty_reg)
                            begin
                                load_res        = 1'b1;
                                res_next.status = lqr_pkg::STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                act_raddr  = head_reg;
                                state_next = ST_POP;
                            end
                        end
                        lqr_pkg::CMD_REVERSE:
                        begin
                            if (empty_reg)
                            begin
                                load_res = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = ST_REV;
                            end
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                load_res           = 1'b1;
                res_next.pop_value = pop_wide[lqr_pkg::VALUE_W-1:0];
                if (head_reg == tail_reg)
                begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end
                else
                begin
                    head_next = head_reg + lqr_pkg::IDX_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_REV:
            begin
                // Read from the tail downwards; the write to the spare bank
                // follows in the next cycle.
                act_raddr    = tail_reg - cnt_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = cnt_reg;
                if (cnt_reg == (tail_reg - head_reg))
                begin
                    state_next = ST_REV_END;
                end
                else
                begin
                    cnt_next = cnt_reg + lqr_pkg::IDX_W'(1);
                end
            end
            ST_REV_END:
            begin
                load_res   = 1'b1;
                sel_next   = !sel_reg;
                head_next  = '0;
                tail_next  = tail_reg - head_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Write stage of the reversal copy.
        if (wr_pend_reg)
        begin
            oth_we = 1'b1;
        end

        if (load_res)
        begin
            res_valid_next      = 1'b1;
            res_next.held_count = held_of(empty_next, head_next, tail_next);
        end
        else
        begin
            res_next = res_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= wr_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        res_reg     <= res_next;
    end

    // An empty queue always has both indices at the start.
    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with non-zero indices");

    // The result register is free whenever a multi-cycle command finishes.
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP || state_reg == ST_REV_END) |-> !res_valid_reg)
        else $error("result register busy at end of command");

    // The copy counter stays inside the held words.
    a_rev_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV) |-> (cnt_reg <= (tail_reg - head_reg)) && !empty_reg)
        else $error("reversal counter out of range");

    // Spare bank writes only happen during a reversal.
    a_wr_pend: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == ST_REV || state_reg == ST_REV_END))
        else $error("spare bank write outside reversal");

    // Finishing a reversal swaps banks and rebases the head.
    a_rev_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV_END) |=> (head_reg == '0) && (sel_reg != $past(sel_reg)))
        else $error("reversal did not swap banks");

endmodule

FILE: hw/rtl/lqr_ram.sv
module lqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; a read of the address
    // being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/linear_queue_with_reverse_tb.sv
module linear_queue_with_reverse_tb;

    // The command code that the block does not use.
    localparam logic [lqr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [lqr_pkg::VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [lqr_pkg::VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int PAUSE_AT_ITEM  = 1000;
    localparam int PHASE_ITEMS    = 24;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // Mirror of the queue: it predicts one result for every command transfer
    // and checks the results in order against those predictions.
    class queue_scoreboard;
        lqr_pkg::word_t     slots [lqr_pkg::DEPTH];
        int                 head_idx;
        int                 tail_idx;
        bit                 is_empty;
        lqr_pkg::res_item_t expected_q [$];
        int                 errors;

        function new();
            head_idx = 0;
            tail_idx = 0;
            is_empty = 1'b1;
            errors   = 0;
            foreach (slots[i])
                slots[i] = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(lqr_pkg::cmd_item_t item);
            lqr_pkg::res_item_t exp_res;
            lqr_pkg::word_t     flipped [lqr_pkg::DEPTH];
            int                 n;

            exp_res = '0;
            case (item.cmd)
                lqr_pkg::CMD_ENQUEUE:
                begin
                    if (is_empty)
                    begin
                        head_idx = 0;
                        tail_idx = 0;
                        slots[0] = item.push_value;
                        is_empty = 1'b0;
                    end
                    else if (tail_idx >= lqr_pkg::DEPTH - 1)
                    begin
                        // The queue is linear: freed head slots are not reused.
                        exp_res.status = lqr_pkg::STATUS_OVERFLOW;
                    end
                    else
                    begin
                        tail_idx++;
                        slots[tail_idx] = item.push_value;
                    end
                end
                lqr_pkg::CMD_DEQUEUE:
                begin
                    if (is_empty)
                        exp_res.status = lqr_pkg::STATUS_UNDERFLOW;
                    else
                    begin
                        exp_res.pop_value = slots[head_idx];
                        if (head_idx >= tail_idx)
                        begin
                            is_empty = 1'b1;
                            head_idx = 0;
                            tail_idx = 0;
                        end
                        else
                            head_idx++;
                    end
                end
                lqr_pkg::CMD_REVERSE:
                begin
                    // Held words are rewritten backwards from slot 0.
                    if (!is_empty)
                    begin
                        n = tail_idx - head_idx + 1;
                        for (int i = 0; i < n; i++)
                            flipped[i] = slots[tail_idx - i];
                        for (int i = 0; i < n; i++)
                            slots[i] = flipped[i];
                        head_idx = 0;
                        tail_idx = n - 1;
                    end
                end
                default:
                begin
                end
            endcase
            exp_res.held_count = is_empty ? '0
                                          : lqr_pkg::HELD_W'(tail_idx - head_idx + 1);
            expected_q.push_back(exp_res);
        endfunction

        function void check_result(lqr_pkg::res_item_t got);
            lqr_pkg::res_item_t exp_res;

            if (expected_q.size() == 0)
            begin
                $error("Result transfer with nothing expected: pop_value %0d status %0d held %0d",
                       got.pop_value, got.status, got.held_count);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.pop_value !== exp_res.pop_value)
            begin
                $error("pop_value: expected %0d, actual %0d", exp_res.pop_value, got.pop_value);
                errors++;
            end
            if (got.status !== exp_res.status)
            begin
                $error("status: expected %0d, actual %0d", exp_res.status, got.status);
                errors++;
            end
            if (got.held_count !== exp_res.held_count)
            begin
                $error("held_count: expected %0d, actual %0d",
                       exp_res.held_count, got.held_count);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    lqr_pkg::cmd_item_t cmd_data;
    logic               res_valid;
    logic               res_stall;
    lqr_pkg::res_item_t res_data;

    queue_scoreboard board;
    bit              send_quiet;
    int              idle_cycles;

    linear_queue_with_reverse u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int gap_len(bit quiet);
        int roll;

        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Mostly random words, with the extremes mixed in.
    function automatic logic signed [lqr_pkg::VALUE_W-1:0] pick_word();
        case ($urandom_range(31))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offers one command after a random gap and holds it until the transfer.
    // Called and returning at a rising edge; stall is sampled at the falling
    // edge, where nothing is moving.
    task automatic send_command(input logic [lqr_pkg::CMD_W-1:0] op,
                                input logic signed [lqr_pkg::VALUE_W-1:0] value);
        lqr_pkg::cmd_item_t item;
        int                 gap;
        bit                 taken;

        item.cmd        = op;
        item.push_value = value;
        if ($urandom_range(63) == 0)
            send_quiet = !send_quiet;
        gap = gap_len(send_quiet);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        do
        begin
            @(negedge clk);
            taken = !cmd_stall;
            @(posedge clk);
        end
        while (!taken);
        board.note_command(item);
    endtask

    // Drops the valid and waits for every predicted result to arrive.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Result side: random stall bursts, plus two long hold-offs that make
    // the block back up and stall its input.
    initial
    begin
        int hold_left;
        int cycle;
        bit quiet;

        hold_left = 0;
        cycle     = 0;
        quiet     = 1'b0;
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle == 1200 || cycle == 3000)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= 1'b0;
                if ($urandom_range(49) == 0)
                    quiet = !quiet;
                hold_left = gap_len(quiet);
            end
        end
    end

    // Checks each result transfer just before the edge that completes it,
    // and ends the run if nothing moves for too long.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                board.check_result(res_data);
            if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int                        enq_pct;
        int                        roll;
        logic [lqr_pkg::CMD_W-1:0] op;

        board       = new();
        send_quiet  = 1'b0;
        idle_cycles = 0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue cases, the unused code, extremes of the word,
        // the last word leaving, a full tail, a full tail with freed head
        // slots, and reverse compacting and then on a full queue.
        send_command(lqr_pkg::CMD_DEQUEUE, '0);
        send_command(lqr_pkg::CMD_REVERSE, '1);
        send_command(CMD_UNUSED, '1);
        send_command(lqr_pkg::CMD_ENQUEUE, WORD_MAX);
        send_command(lqr_pkg::CMD_ENQUEUE, WORD_MIN);
        send_command(lqr_pkg::CMD_DEQUEUE, '1);
        send_command(lqr_pkg::CMD_DEQUEUE, '0);
        send_command(lqr_pkg::CMD_DEQUEUE, '0);
        for (int i = 0; i < lqr_pkg::DEPTH; i++)
            send_command(lqr_pkg::CMD_ENQUEUE,
                         (i == 0) ? '0 : (i == 1) ? '1 : pick_word());
        send_command(lqr_pkg::CMD_ENQUEUE, WORD_MAX);
        send_command(lqr_pkg::CMD_DEQUEUE, '0);
        send_command(lqr_pkg::CMD_DEQUEUE, '0);
        send_command(lqr_pkg::CMD_ENQUEUE, WORD_MIN);
        send_command(lqr_pkg::CMD_REVERSE, '0);
        send_command(lqr_pkg::CMD_ENQUEUE, 32'sh5555_5555);
        send_command(lqr_pkg::CMD_ENQUEUE, 32'shAAAA_AAAA);
        send_command(lqr_pkg::CMD_REVERSE, WORD_MAX);
        send_command(CMD_UNUSED, '0);

        // Random: phases that lean towards filling or towards draining, so
        // that the full tail and the empty queue are both reached often.
        enq_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            if (n == PAUSE_AT_ITEM)
                wait_drained();
            roll = $urandom_range(99);
            if (roll < 3)
                op = CMD_UNUSED;
            else if (roll < 11)
                op = lqr_pkg::CMD_REVERSE;
            else if (roll < 11 + enq_pct * 89 / 100)
                op = lqr_pkg::CMD_ENQUEUE;
            else
                op = lqr_pkg::CMD_DEQUEUE;
            send_command(op, pick_word());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lqr_pkg.sv
hw/rtl/lqr_ram.sv
hw/rtl/linear_queue_with_reverse.sv
tb/linear_queue_with_reverse_tb.sv
